/* src/crmu_pkg.sv */
// ----------------------------------------------------------------------------
// crmu_pkg
// Types, codes and helpers for the correlation registry match/upsert block.
// ----------------------------------------------------------------------------
package crmu_pkg;

  localparam int unsigned DefDepth = 64;

  localparam int unsigned KeyW    = 32;
  localparam int unsigned CodeW   = 48;
  localparam int unsigned MarketW = 2;
  localparam int unsigned TypeW   = 3;
  localparam int unsigned ModeW   = 32;

  // operations
  localparam logic OpMatch  = 1'b0;
  localparam logic OpUpsert = 1'b1;

  // status codes
  localparam logic [2:0] StOk        = 3'd0;
  localparam logic [2:0] StBadType   = 3'd1;
  localparam logic [2:0] StBadMarket = 3'd2;
  localparam logic [2:0] StBadCode   = 3'd3;
  localparam logic [2:0] StFull      = 3'd4;

  // outcome codes
  localparam logic [2:0] OutNone     = 3'd0;
  localparam logic [2:0] OutRetained = 3'd1;
  localparam logic [2:0] OutRemoved  = 3'd2;
  localparam logic [2:0] OutReplaced = 3'd3;
  localparam logic [2:0] OutAppended = 3'd4;

  localparam logic [ModeW-1:0] ModeKeep  = 32'd9;
  localparam logic [7:0]       MarketMax = 8'd2;
  localparam logic [TypeW-1:0] TypeLimit = 3'd6;

  typedef struct packed {
    logic [2*KeyW-1:0]  keys;    // key_first high, key_second low
    logic [CodeW-1:0]   code;
    logic [MarketW-1:0] market;
    logic [TypeW-1:0]   dtype;
    logic [ModeW-1:0]   mode;
  } entry_t;

  // every byte of the code must be an ASCII digit
  function automatic logic code_ok(input logic [CodeW-1:0] code);
    logic ok;
    logic [7:0] b;
    ok = 1'b1;
    for (int i = 0; i < CodeW / 8; i++) begin
      b = code[8*i +: 8];
      if (b < 8'h30 || b > 8'h39) ok = 1'b0;
    end
    return ok;
  endfunction

endpackage

/* src/correlation_registry_match_upsert.sv */
// ----------------------------------------------------------------------------
// correlation_registry_match_upsert
// Ordered registry of callback keys with match/remove and upsert/append.
// ----------------------------------------------------------------------------
//
// Channel  | Direction | Handshake                    | Payload
// ---------+-----------+------------------------------+-------------------------
// request  | in        | start_i, accepted when !busy | op, type, keys, market,
//          |           |                              | code, mode
// result   | out       | done_o, one-cycle strobe     | status, matched, index,
//          |           |                              | outcome, matched fields,
//          |           |                              | held count
//
// Sequence: busy_o covers a checking step, a memory read and a compare for
// each record compared, an end step when the scan runs off the end, and a
// read and a write for each record moved up on a removal. The result strobe
// rises in the same cycle that busy_o falls. The longest busy run is a scan
// with no match on a full table. The separate read and compare steps are set
// by the single registered read port of the record memory.
// Reset: only the record count and the control state are cleared; the memory
// holds garbage above the count and its contents there are never used.
// Stalls: none on the result side; done_o is a strobe and busy_o is low again
// in the cycle the result is shown, so a new request can be taken there.
//
module correlation_registry_match_upsert #(
  parameter int unsigned DEPTH = crmu_pkg::DefDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        op_i,
  input  logic [2:0]  data_type_code_i,
  input  logic [31:0] key_first_i,
  input  logic [31:0] key_second_i,
  input  logic [7:0]  market_i,
  input  logic [47:0] code_digits_i,
  input  logic [31:0] mode_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic        matched_o,
  output logic [5:0]  match_pos_o,
  output logic [2:0]  outcome_o,
  output logic [31:0] matched_mode_o,
  output logic [1:0]  matched_market_o,
  output logic [47:0] matched_code_o,
  output logic [6:0]  held_count_o
);

  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  // sequencer codes
  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SCheck = 3'd1;  // validate request
  localparam logic [2:0] SRead  = 3'd2;  // issue read of record ptr
  localparam logic [2:0] SCmp   = 3'd3;  // compare registered record
  localparam logic [2:0] SEnd   = 3'd4;  // scan ran off the end
  localparam logic [2:0] SShRd  = 3'd5;  // read record ptr+1
  localparam logic [2:0] SShWr  = 3'd6;  // write it to ptr

  logic [2:0]      state_q, state_d;
  logic [IdxW-1:0] ptr_q, ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            done_q;

  // latched request
  logic                         op_q;
  logic [crmu_pkg::TypeW-1:0]   type_q;
  logic [2*crmu_pkg::KeyW-1:0]  keys_q;
  logic [7:0]                   market_q;
  logic [crmu_pkg::CodeW-1:0]   code_q;
  logic [crmu_pkg::ModeW-1:0]   mode_q;

  // record memory, one registered read port, one write port
  crmu_pkg::entry_t mem_q [DEPTH];
  crmu_pkg::entry_t rd_q;
  logic [IdxW-1:0]  rd_addr;
  logic             we;
  logic [IdxW-1:0]  waddr;
  crmu_pkg::entry_t wdata;

  // result staging
  logic                         res_ld, fin;
  logic [2:0]                   r_status, r_outcome;
  logic                         r_matched;
  logic [crmu_pkg::ModeW-1:0]   r_mmode;
  logic [crmu_pkg::MarketW-1:0] r_mmarket;
  logic [crmu_pkg::CodeW-1:0]   r_mcode;

  logic [CntW-1:0]  ptr_inc;
  logic             hit;
  crmu_pkg::entry_t upd;

  assign busy_o  = (state_q != SIdle);
  assign ptr_inc = CntW'(ptr_q) + CntW'(1);

  // the one compare unit: match key depends on the operation
  always_comb begin
    if (op_q == crmu_pkg::OpMatch) begin
      hit = (rd_q.dtype == type_q) && (rd_q.keys == keys_q);
    end else begin
      hit = (rd_q.dtype == type_q) && (rd_q.mode == mode_q) &&
            (rd_q.market == market_q[crmu_pkg::MarketW-1:0]) &&
            (rd_q.code == code_q);
    end
  end

  always_comb begin
    upd      = rd_q;
    upd.keys = keys_q;
  end

  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    count_d   = count_q;
    res_ld    = 1'b0;
    fin       = 1'b0;
    r_status  = crmu_pkg::StOk;
    r_matched = 1'b0;
    r_outcome = crmu_pkg::OutNone;
    r_mmode   = '0;
    r_mmarket = '0;
    r_mcode   = '0;
    we        = 1'b0;
    waddr     = ptr_q;
    wdata     = rd_q;
    rd_addr   = ptr_q;

    unique case (state_q)
      SIdle: begin
        if (start_i) state_d = SCheck;
      end
      SCheck: begin
        ptr_d = '0;
        if (op_q == crmu_pkg::OpUpsert && market_q > crmu_pkg::MarketMax) begin
          r_status = crmu_pkg::StBadMarket;
          res_ld = 1'b1; fin = 1'b1; state_d = SIdle;
        end else if (op_q == crmu_pkg::OpUpsert && !crmu_pkg::code_ok(code_q)) begin
          r_status = crmu_pkg::StBadCode;
          res_ld = 1'b1; fin = 1'b1; state_d = SIdle;
        end else if (type_q >= crmu_pkg::TypeLimit) begin
          r_status = crmu_pkg::StBadType;
          res_ld = 1'b1; fin = 1'b1; state_d = SIdle;
        end else if (count_q == '0) begin
          state_d = SEnd;
        end else begin
          state_d = SRead;
        end
      end
      SRead: begin
        state_d = SCmp;
      end
      SCmp: begin
        if (hit) begin
          r_matched = 1'b1;
          res_ld    = 1'b1;
          if (op_q == crmu_pkg::OpMatch) begin
            r_mmode   = rd_q.mode;
            r_mmarket = rd_q.market;
            r_mcode   = rd_q.code;
            if (rd_q.mode == crmu_pkg::ModeKeep) begin
              r_outcome = crmu_pkg::OutRetained;
              fin = 1'b1; state_d = SIdle;
            end else begin
              r_outcome = crmu_pkg::OutRemoved;
              if (ptr_inc < count_q) begin
                state_d = SShRd;
              end else begin
                count_d = count_q - CntW'(1);
                fin = 1'b1; state_d = SIdle;
              end
            end
          end else begin
            r_outcome = crmu_pkg::OutReplaced;
            we = 1'b1; wdata = upd;
            fin = 1'b1; state_d = SIdle;
          end
        end else if (ptr_inc < count_q) begin
          ptr_d   = ptr_inc[IdxW-1:0];
          state_d = SRead;
        end else begin
          state_d = SEnd;
        end
      end
      SEnd: begin
        res_ld = 1'b1; fin = 1'b1; state_d = SIdle;
        if (op_q == crmu_pkg::OpUpsert) begin
          if (count_q >= CntW'(DEPTH)) begin
            r_status = crmu_pkg::StFull;
          end else begin
            r_outcome    = crmu_pkg::OutAppended;
            we           = 1'b1;
            waddr        = count_q[IdxW-1:0];
            wdata.keys   = keys_q;
            wdata.code   = code_q;
            wdata.market = market_q[crmu_pkg::MarketW-1:0];
            wdata.dtype  = type_q;
            wdata.mode   = mode_q;
            count_d      = count_q + CntW'(1);
          end
        end
      end
      SShRd: begin
        rd_addr = ptr_inc[IdxW-1:0];
        state_d = SShWr;
      end
      SShWr: begin
        we = 1'b1;  // wdata is the record just read from ptr+1
        if (ptr_inc < count_q - CntW'(1)) begin
          ptr_d   = ptr_inc[IdxW-1:0];
          state_d = SShRd;
        end else begin
          count_d = count_q - CntW'(1);
          fin = 1'b1; state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= fin;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    if (start_i && !busy_o) begin
      op_q     <= op_i;
      type_q   <= data_type_code_i;
      keys_q   <= {key_first_i, key_second_i};
      market_q <= market_i;
      code_q   <= code_digits_i;
      mode_q   <= mode_i;
    end
    if (res_ld) begin
      status_o         <= r_status;
      matched_o        <= r_matched;
      match_pos_o      <= r_matched ? 6'(ptr_q) : 6'd0;
      outcome_o        <= r_outcome;
      matched_mode_o   <= r_mmode;
      matched_market_o <= r_mmarket;
      matched_code_o   <= r_mcode;
    end
    if (fin) held_count_o <= 7'(count_d);
  end

  // record memory
  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    rd_q <= mem_q[rd_addr];
  end

  assign done_o = done_q;

  // assertions
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result shown while busy");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH)) else $error("record count above depth");

  a_accept_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> state_q == SCheck) else $error("request not taken");

  a_remove_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && outcome_o == crmu_pkg::OutRemoved) |->
      count_q + CntW'(1) == $past(count_q)) else $error("removal count slip");

  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != crmu_pkg::StOk) |->
      (outcome_o == crmu_pkg::OutNone && !matched_o)) else $error("error with outcome");

endmodule
